[hw/rtl/kdas_pkg.sv]
package kdas_pkg;

  // Key counts follow the fixed pin fields of the input beat.
  localparam int CHAN_KEYS  = 4;
  localparam int TRIM_KEYS  = 8;
  localparam int COUNT_BITS = 8;
  localparam int CFG_BITS   = 8;
  localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  localparam int SLOTS          = CHAN_KEYS + TRIM_KEYS;
  localparam int SLOT_BITS      = $clog2(SLOTS);
  localparam int TRIM_IDX_BITS  = $clog2(TRIM_KEYS);
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(SLOTS - 1);
  localparam logic [SLOT_BITS-1:0]  FIRST_TRIM_SLOT = SLOT_BITS'(CHAN_KEYS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STICK_MODE    = 3'd0,
    REG_CLICK_PRESS   = 3'd1,
    REG_CLICK_RELEASE = 3'd2,
    REG_TRIM_SHORT    = 3'd3,
    REG_TRIM_HOLD     = 3'd4,
    REG_TRIM_REPEAT   = 3'd5,
    REG_TRIM_RELEASE  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] channel_keys_n;
    logic [7:0] trim_keys_n;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] channel_event;
    logic [3:0] trim_event;
  } out_beat_t;

  typedef struct packed {
    logic                stick_mode;
    logic [CFG_BITS-1:0] click_press_ticks;
    logic [CFG_BITS-1:0] click_release_ticks;
    logic [CFG_BITS-1:0] trim_short_ticks;
    logic [CFG_BITS-1:0] trim_hold_ticks;
    logic [CFG_BITS-1:0] trim_repeat_ticks;
    logic [CFG_BITS-1:0] trim_release_ticks;
  } cfg_t;

  // One state word per key. Channel keys leave rep_cnt at zero.
  typedef struct packed {
    logic [COUNT_BITS-1:0] down_cnt;
    logic [COUNT_BITS-1:0] up_cnt;
    logic [COUNT_BITS-1:0] rep_cnt;
  } key_entry_t;

  localparam int ENTRY_BITS = $bits(key_entry_t);

  // Trim scan order: throttle+, throttle-, elevator+, elevator-, rudder+, rudder-,
  // aileron+, aileron-. Event code of each trim scan position.
  localparam logic [3:0] TRIM_CODE [TRIM_KEYS] = '{
    4'd3, 4'd4, 4'd7, 4'd8, 4'd1, 4'd2, 4'd5, 4'd6
  };

  // Pin of each trim scan position in mode two and in the swapped mapping.
  localparam logic [2:0] TRIM_PIN_MODE2 [TRIM_KEYS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
  };
  localparam logic [2:0] TRIM_PIN_SWAP [TRIM_KEYS] = '{
    3'd2, 3'd3, 3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7
  };

  function automatic logic [CMP_BITS-1:0] ext_cnt(input logic [COUNT_BITS-1:0] v);
    return CMP_BITS'(v);
  endfunction

  function automatic logic [CMP_BITS-1:0] ext_thr(input logic [CFG_BITS-1:0] v);
    return CMP_BITS'(v);
  endfunction

  function automatic logic slot_is_trim(input logic [SLOT_BITS-1:0] slot);
    return slot >= FIRST_TRIM_SLOT;
  endfunction

  function automatic logic [TRIM_IDX_BITS-1:0] trim_idx(input logic [SLOT_BITS-1:0] slot);
    logic [SLOT_BITS-1:0] diff;
    diff = slot - FIRST_TRIM_SLOT;
    return diff[TRIM_IDX_BITS-1:0];
  endfunction

  // Pressed level of the key scanned at a slot (pins are active low).
  function automatic logic slot_pressed(input logic [SLOT_BITS-1:0] slot,
                                        input in_beat_t             beat,
                                        input logic                 stick_mode);
    logic [2:0] pin;
    logic [1:0] chan;
    chan = slot[1:0];
    pin  = stick_mode ? TRIM_PIN_MODE2[trim_idx(slot)] : TRIM_PIN_SWAP[trim_idx(slot)];
    if (slot_is_trim(slot)) begin
      return !beat.trim_keys_n[pin];
    end
    return !beat.channel_keys_n[chan];
  endfunction

endpackage

[hw/rtl/kdas_state_ram.sv]
module kdas_state_ram (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  re_i,
  input  logic [kdas_pkg::SLOT_BITS-1:0]        raddr_i,
  output kdas_pkg::key_entry_t                  rdata_o,
  input  logic                                  we_i,
  input  logic [kdas_pkg::SLOT_BITS-1:0]        waddr_i,
  input  kdas_pkg::key_entry_t                  wdata_i
);

  kdas_pkg::key_entry_t             mem [kdas_pkg::SLOTS];
  logic [kdas_pkg::SLOTS-1:0]       valid_q;
  kdas_pkg::key_entry_t             rdata_q;
  logic                             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // An entry never written since reset reads as all-zero counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[hw/rtl/kdas_key_update.sv]
module kdas_key_update (
  input  logic                 is_trim_i,
  input  logic                 pressed_i,
  input  kdas_pkg::key_entry_t cur_i,
  input  kdas_pkg::cfg_t       cfg_i,
  output kdas_pkg::key_entry_t nxt_o,
  output logic                 fire_o
);

  logic [kdas_pkg::COUNT_BITS-1:0] down_inc;
  logic click_down_room, click_up_room, trim_down_room, trim_rep_room, trim_up_room;

  assign down_inc = cur_i.down_cnt + kdas_pkg::COUNT_BITS'(1);

  assign click_down_room = (kdas_pkg::ext_cnt(cur_i.down_cnt)
                            < kdas_pkg::ext_thr(cfg_i.click_press_ticks))
                           && (cur_i.down_cnt != kdas_pkg::CNT_MAX);
  assign click_up_room   = (kdas_pkg::ext_cnt(cur_i.up_cnt)
                            < kdas_pkg::ext_thr(cfg_i.click_release_ticks))
                           && (cur_i.up_cnt != kdas_pkg::CNT_MAX);
  assign trim_down_room  = (kdas_pkg::ext_cnt(cur_i.down_cnt)
                            < kdas_pkg::ext_thr(cfg_i.trim_hold_ticks))
                           && (cur_i.down_cnt != kdas_pkg::CNT_MAX);
  assign trim_rep_room   = (kdas_pkg::ext_cnt(cur_i.rep_cnt)
                            < kdas_pkg::ext_thr(cfg_i.trim_repeat_ticks))
                           && (cur_i.rep_cnt != kdas_pkg::CNT_MAX);
  assign trim_up_room    = (kdas_pkg::ext_cnt(cur_i.up_cnt)
                            < kdas_pkg::ext_thr(cfg_i.trim_release_ticks))
                           && (cur_i.up_cnt != kdas_pkg::CNT_MAX);

  always_comb begin
    nxt_o  = cur_i;
    fire_o = 1'b0;
    if (is_trim_i) begin
      if (pressed_i) begin
        nxt_o.up_cnt = '0;
        if (trim_down_room) begin
          nxt_o.down_cnt = down_inc;
          nxt_o.rep_cnt  = '0;
          fire_o = kdas_pkg::ext_cnt(down_inc) == kdas_pkg::ext_thr(cfg_i.trim_short_ticks);
        end else if (trim_rep_room) begin
          nxt_o.rep_cnt = cur_i.rep_cnt + kdas_pkg::COUNT_BITS'(1);
        end else begin
          nxt_o.rep_cnt = '0;
          fire_o = 1'b1;
        end
      end else if (trim_up_room) begin
        nxt_o.up_cnt = cur_i.up_cnt + kdas_pkg::COUNT_BITS'(1);
      end else begin
        nxt_o.down_cnt = '0;
      end
    end else begin
      if (pressed_i) begin
        if (click_down_room) begin
          nxt_o.down_cnt = down_inc;
        end
        nxt_o.up_cnt = '0;
      end else if (click_up_room) begin
        nxt_o.up_cnt = cur_i.up_cnt + kdas_pkg::COUNT_BITS'(1);
      end else begin
        // A click counts only if the press lasted long enough.
        fire_o = kdas_pkg::ext_cnt(cur_i.down_cnt)
                 >= kdas_pkg::ext_thr(cfg_i.click_press_ticks);
        nxt_o.down_cnt = '0;
      end
    end
  end

endmodule

[hw/rtl/key_debounce_autorepeat_scanner_unit.sv]
// Key debounce and auto-repeat scanner.
// Each input beat is one scan tick: the active-low levels of four channel keys
// and eight trim keys. Each tick yields exactly one output beat carrying the
// channel click event and the trim event of that tick (zero when no key fires;
// when several keys of one group fire, the one scanned last wins).
// All per-key counters live in one twelve-entry state memory with a registered
// read port. A sequencer walks the keys one per cycle while the scan is not
// frozen: it reads a key's entry, updates it from the registered read data
// and writes it back while the following key is read. A tick therefore holds
// the memory port for one read and one write per key, which sets the
// sustained rate.
// A one-beat input buffer takes the next tick while the current one is being
// scanned, and a result register holds the finished beat for the receiver.
// When the receiver stalls, the result stays put; the scan of the next tick
// halts just before it would deliver its own result, and the input buffer
// fills and then stalls the sender.
// Reset restores the control and config registers to defaults and marks every
// memory entry as zero by per-entry valid bits, so no clearing pass is needed.
// Configuration writes are taken at any time but should only be made idle.
module key_debounce_autorepeat_scanner_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  kdas_pkg::in_beat_t                     in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output kdas_pkg::out_beat_t                    out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [kdas_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [kdas_pkg::CFG_BITS-1:0]          cfg_wdata_i
);

  kdas_pkg::cfg_t cfg_q;

  // Input buffer and the tick being scanned.
  logic                             in_full_q;
  kdas_pkg::in_beat_t               in_buf_q;
  logic                             busy_q;
  logic [kdas_pkg::SLOT_BITS-1:0]   slot_q;
  kdas_pkg::in_beat_t               job_q;

  // Update stage: the key whose entry comes back from memory this cycle.
  logic                             s1_valid_q;
  logic                             s1_last_q;
  logic                             s1_first_q;
  logic                             s1_pressed_q;
  logic [kdas_pkg::SLOT_BITS-1:0]   s1_slot_q;

  logic [2:0]                       chan_acc_q, chan_base, chan_nx;
  logic [3:0]                       trim_acc_q, trim_base, trim_nx;

  logic                             out_valid_q;
  kdas_pkg::out_beat_t              out_q;

  logic                             adv, take_job, s0_last, in_acc;
  logic                             ram_re, ram_we, s1_is_trim, fire;
  kdas_pkg::key_entry_t             ram_rdata, upd_entry;

  assign in_stall_o  = in_full_q;
  assign in_acc      = in_valid_i && !in_full_q;
  assign s0_last     = slot_q == kdas_pkg::LAST_SLOT;
  // The scan freezes only when a finished result cannot enter the output register.
  assign adv         = !(s1_valid_q && s1_last_q && out_valid_q && out_stall_i);
  assign take_job    = adv && (!busy_q || s0_last);
  assign ram_re      = adv && busy_q;
  assign ram_we      = adv && s1_valid_q;
  assign s1_is_trim  = kdas_pkg::slot_is_trim(s1_slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_mode          <= 1'b1;
      cfg_q.click_press_ticks   <= 8'd4;
      cfg_q.click_release_ticks <= 8'd5;
      cfg_q.trim_short_ticks    <= 8'd5;
      cfg_q.trim_hold_ticks     <= 8'd50;
      cfg_q.trim_repeat_ticks   <= 8'd15;
      cfg_q.trim_release_ticks  <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdas_pkg::REG_STICK_MODE:    cfg_q.stick_mode          <= cfg_wdata_i[0];
        kdas_pkg::REG_CLICK_PRESS:   cfg_q.click_press_ticks   <= cfg_wdata_i;
        kdas_pkg::REG_CLICK_RELEASE: cfg_q.click_release_ticks <= cfg_wdata_i;
        kdas_pkg::REG_TRIM_SHORT:    cfg_q.trim_short_ticks    <= cfg_wdata_i;
        kdas_pkg::REG_TRIM_HOLD:     cfg_q.trim_hold_ticks     <= cfg_wdata_i;
        kdas_pkg::REG_TRIM_REPEAT:   cfg_q.trim_repeat_ticks   <= cfg_wdata_i;
        kdas_pkg::REG_TRIM_RELEASE:  cfg_q.trim_release_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_buf_q <= in_data_i;
    end
    if (take_job) begin
      job_q <= in_buf_q;
    end
    if (adv) begin
      s1_slot_q    <= slot_q;
      s1_pressed_q <= kdas_pkg::slot_pressed(slot_q, job_q, cfg_q.stick_mode);
      s1_last_q    <= s0_last;
      s1_first_q   <= slot_q == '0;
    end
    if (ram_we) begin
      chan_acc_q <= chan_nx;
      trim_acc_q <= trim_nx;
    end
    if (ram_we && s1_last_q) begin
      out_q.channel_event <= chan_nx;
      out_q.trim_event    <= trim_nx;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      busy_q      <= 1'b0;
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_full_q <= 1'b1;
      end else if (take_job) begin
        in_full_q <= 1'b0;
      end
      if (take_job) begin
        busy_q <= in_full_q;
        slot_q <= '0;
      end else if (adv && busy_q) begin
        slot_q <= slot_q + kdas_pkg::SLOT_BITS'(1);
      end
      if (adv) begin
        s1_valid_q <= busy_q;
      end
      if (ram_we && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  kdas_state_ram u_state_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (s1_slot_q),
    .wdata_i (upd_entry)
  );

  kdas_key_update u_key_update (
    .is_trim_i (s1_is_trim),
    .pressed_i (s1_pressed_q),
    .cur_i     (ram_rdata),
    .cfg_i     (cfg_q),
    .nxt_o     (upd_entry),
    .fire_o    (fire)
  );

  // Event accumulation: the first key of a tick starts from no event, and every
  // later key that fires overwrites the event of its own group.
  always_comb begin
    chan_base = s1_first_q ? '0 : chan_acc_q;
    trim_base = s1_first_q ? '0 : trim_acc_q;
    chan_nx   = chan_base;
    trim_nx   = trim_base;
    if (fire && s1_is_trim) begin
      trim_nx = kdas_pkg::TRIM_CODE[kdas_pkg::trim_idx(s1_slot_q)];
    end else if (fire) begin
      chan_nx = 3'(s1_slot_q) + 3'd1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The write-back of one key never lands on the entry being read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> s1_slot_q != slot_q)
    else $error("state memory read and write hit the same key");

  // A finished tick always reaches the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && s1_last_q |=> out_valid_q)
    else $error("scan result was dropped");

  // A buffered tick handed to the sequencer starts at the first key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_job && in_full_q |=> busy_q && slot_q == '0)
    else $error("sequencer did not start a buffered tick");

  // Result codes stay within their defined ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.channel_event <= 3'd4 && out_q.trim_event <= 4'd8)
    else $error("event code out of range");

  // Except for the last key, the update stage holds a key only during a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_last_q |-> busy_q)
    else $error("update stage active without a tick in progress");

endmodule
